/* sv/sma_pkg.sv */
// Shared types and constants for the sign-magnitude ALU.
// No dependencies; every other file of the block imports this package.
package sma_pkg;

  // Fixed port widths
  localparam int unsigned IN_MAG_W = 31;
  localparam int unsigned RES_W    = 62;

  // Operation codes carried on in_kind
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } sma_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_SWAP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } sma_state_t;

  // Step commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic addsub;
    logic swap;
    logic mul;
    logic div;
    logic finish;
  } sma_ctrl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic borrow;
    logic out_free;
  } sma_stat_t;

endpackage

/* sv/sma_ctrl.sv */
// Sequencer of the sign-magnitude ALU: state machine and step counter.
// Depends on sma_pkg; drives the shared adder steps in sma_dp.
module sma_ctrl #(
  parameter int unsigned MAG_BITS = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sma_pkg::sma_op_t  in_kind,
  output logic              in_stall,
  input  sma_pkg::sma_stat_t stat,
  output sma_pkg::sma_ctrl_t ctl
);
  import sma_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAG_BITS);

  sma_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_last;

  assign cnt_last = (cnt_r == CNT_W'(0));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            OP_ADD:  state_nxt = ST_ADDSUB;
            OP_SUB:  state_nxt = ST_ADDSUB;
            OP_MUL:  state_nxt = ST_MUL;
            OP_DIV:  state_nxt = ST_DIV;
            default: state_nxt = ST_ADDSUB;
          endcase
        end
      end
      ST_ADDSUB: state_nxt = stat.borrow ? ST_SWAP : ST_DONE;
      ST_SWAP:   state_nxt = ST_DONE;
      ST_MUL:    state_nxt = cnt_last ? ST_DONE : ST_MUL;
      ST_DIV:    state_nxt = cnt_last ? ST_DONE : ST_DIV;
      ST_DONE:   state_nxt = stat.out_free ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: step commands and input stall
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      ST_ADDSUB: ctl.addsub = 1'b1;
      ST_SWAP:   ctl.swap   = 1'b1;
      ST_MUL:    ctl.mul    = 1'b1;
      ST_DIV:    ctl.div    = 1'b1;
      ST_DONE:   ctl.finish = stat.out_free;
      default:   in_stall   = 1'b1;
    endcase
  end

  // Step counter: reload on a new transaction, count down while iterating
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      cnt_nxt = CNT_W'(MAG_BITS - 1);
    end else if (ctl.mul || ctl.div) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_mul_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && cnt_last) |=> state_r == ST_DONE)
    else $error("multiply did not end after its last step");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_last) |=> state_r == ST_DONE)
    else $error("divide did not end after its last step");

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (state_r != ST_IDLE && cnt_r == CNT_W'(MAG_BITS - 1)))
    else $error("accepted transaction did not start a sequence");
`endif

endmodule

/* sv/sma_dp.sv */
// Datapath of the sign-magnitude ALU: one shared add/subtract unit,
// operand and partial-result registers, and the output register.
// Depends on sma_pkg; stepped by sma_ctrl.
module sma_dp #(
  parameter int unsigned MAG_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sma_pkg::sma_ctrl_t            ctl,
  output sma_pkg::sma_stat_t            stat,
  input  sma_pkg::sma_op_t              in_kind,
  input  logic [sma_pkg::IN_MAG_W-1:0]  in_operand_a_magnitude,
  input  logic                          in_operand_a_negative,
  input  logic [sma_pkg::IN_MAG_W-1:0]  in_operand_b_magnitude,
  input  logic                          in_operand_b_negative,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sma_pkg::RES_W-1:0]     out_result_magnitude,
  output logic                          out_result_negative,
  output logic                          out_divide_by_zero
);
  import sma_pkg::*;

  localparam int unsigned W = MAG_BITS;

  // Working registers
  sma_op_t      op_r;
  logic         sa_r, sb_r;
  logic [W-1:0] hi_r, hi_nxt;
  logic [W-1:0] lo_r, lo_nxt;
  logic [W-1:0] mb_r;
  logic [W:0]   sum_r, sum_nxt;
  logic         neg_r, neg_nxt;
  logic         dz_r;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [RES_W-1:0] out_mag_r, out_mag_nxt;
  logic             out_neg_r, out_neg_nxt;
  logic             out_dz_r;

  // Shared unit
  logic [W:0]   u_a, u_b;
  logic         u_sub;
  logic [W+1:0] u_res;
  logic         u_borrow;
  logic         sb_eff;

  assign sb_eff = sb_r ^ (op_r == OP_SUB);

  // Select the operands of the shared adder for the current step
  always_comb begin
    u_a   = {1'b0, lo_r};
    u_b   = {1'b0, mb_r};
    u_sub = 1'b0;
    if (ctl.addsub) begin
      u_sub = (sa_r != sb_eff);
    end else if (ctl.swap) begin
      u_a   = {1'b0, mb_r};
      u_b   = {1'b0, lo_r};
      u_sub = 1'b1;
    end else if (ctl.mul) begin
      u_a = {1'b0, hi_r};
      u_b = lo_r[0] ? {1'b0, mb_r} : '0;
    end else if (ctl.div) begin
      u_a   = {hi_r, lo_r[W-1]};
      u_sub = 1'b1;
    end
  end

  assign u_res    = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + (W+2)'(u_sub);
  assign u_borrow = u_sub & ~u_res[W+1];

  // Status fields in declaration order: borrow, then out_free
  assign stat = {u_borrow, (!out_valid_r || !out_stall)};

  // Advance the working registers
  always_comb begin
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    sum_nxt = sum_r;
    neg_nxt = neg_r;
    if (ctl.load) begin
      hi_nxt = '0;
      lo_nxt = in_operand_a_magnitude[W-1:0];
    end else if (ctl.addsub) begin
      sum_nxt = u_res[W:0];
      neg_nxt = sa_r;
    end else if (ctl.swap) begin
      sum_nxt = u_res[W:0];
      neg_nxt = sb_eff;
    end else if (ctl.mul) begin
      // shift the product right, taking in the adder carry
      hi_nxt = u_res[W:1];
      lo_nxt = {u_res[0], lo_r[W-1:1]};
    end else if (ctl.div) begin
      // restoring step: keep the trial remainder when it did not borrow
      hi_nxt = u_borrow ? {hi_r[W-2:0], lo_r[W-1]} : u_res[W-1:0];
      lo_nxt = {lo_r[W-2:0], ~u_borrow};
    end
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    sum_r <= sum_nxt;
    neg_r <= neg_nxt;
    if (ctl.load) begin
      op_r <= in_kind;
      sa_r <= in_operand_a_negative;
      sb_r <= in_operand_b_negative;
      mb_r <= in_operand_b_magnitude[W-1:0];
      dz_r <= (in_kind == OP_DIV) && (in_operand_b_magnitude[W-1:0] == '0);
    end
  end

  // Assemble the result; a zero result is always positive
  always_comb begin
    out_mag_nxt = '0;
    out_neg_nxt = sa_r ^ sb_r;
    case (op_r)
      OP_ADD: begin
        out_mag_nxt = RES_W'(sum_r);
        out_neg_nxt = neg_r;
      end
      OP_SUB: begin
        out_mag_nxt = RES_W'(sum_r);
        out_neg_nxt = neg_r;
      end
      OP_MUL:  out_mag_nxt = RES_W'({hi_r, lo_r});
      OP_DIV:  out_mag_nxt = dz_r ? '0 : RES_W'(lo_r);
      default: out_mag_nxt = '0;
    endcase
    if (out_mag_nxt == '0) begin
      out_neg_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = ctl.finish | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the transaction until taken
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_mag_r <= out_mag_nxt;
      out_neg_r <= out_neg_nxt;
      out_dz_r  <= dz_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_magnitude = out_mag_r;
  assign out_result_negative  = out_neg_r;
  assign out_divide_by_zero   = out_dz_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while still held");

  a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_neg_r) |-> out_mag_r != '0)
    else $error("negative zero on the result");

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dz_r) |-> (out_mag_r == '0 && !out_neg_r))
    else $error("divide-by-zero result not cleared");
`endif

endmodule

/* sv/sign_magnitude_alu_core.sv */
// Top level of the sign-magnitude ALU: sequencer plus shared-adder datapath.
// Depends on sma_pkg, sma_ctrl and sma_dp.
//
// Usage:
//   Input channel in_*: operation code and two sign-magnitude operands,
//   taken when in_valid is high and in_stall is low. Only the low MAG_BITS
//   bits of each magnitude are used.
//   Result channel out_*: magnitude, sign and divide-by-zero flag, taken
//   when out_valid is high and out_stall is low.
// Sequencing:
//   One transaction at a time on one shared adder. Add and subtract run an
//   ADDSUB step, plus a SWAP step when the difference changes sign.
//   Multiply (shift-add) and divide (restoring shift-subtract) take one
//   adder pass per magnitude bit. Each then loads its result in DONE.
//   The next transaction can be taken in the cycle after the result loads.
// Reset clears the sequencer and the result valid; no result is pending.
// While the receiver stalls, the result is held in the output register; the
// next transaction may be accepted and worked, and waits in its last step
// until the output register frees.
module sign_magnitude_alu_core #(
  parameter int unsigned MAG_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [sma_pkg::IN_MAG_W-1:0]  in_operand_a_magnitude,
  input  logic                          in_operand_a_negative,
  input  logic [sma_pkg::IN_MAG_W-1:0]  in_operand_b_magnitude,
  input  logic                          in_operand_b_negative,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sma_pkg::RES_W-1:0]     out_result_magnitude,
  output logic                          out_result_negative,
  output logic                          out_divide_by_zero
);
  import sma_pkg::*;

  sma_ctrl_t ctl;
  sma_stat_t stat;
  sma_op_t   kind;

  assign kind = sma_op_t'(in_kind);

  sma_ctrl #(
    .MAG_BITS (MAG_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (kind),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  sma_dp #(
    .MAG_BITS (MAG_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctl                    (ctl),
    .stat                   (stat),
    .in_kind                (kind),
    .in_operand_a_magnitude (in_operand_a_magnitude),
    .in_operand_a_negative  (in_operand_a_negative),
    .in_operand_b_magnitude (in_operand_b_magnitude),
    .in_operand_b_negative  (in_operand_b_negative),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_result_magnitude   (out_result_magnitude),
    .out_result_negative    (out_result_negative),
    .out_divide_by_zero     (out_divide_by_zero)
  );

endmodule
